### sv/plt_pkg.sv
// Shared types and constants for the polyline leading-trim block.
// Used by plt_ctrl, plt_dp and polyline_leading_trim_core; no dependencies.
package plt_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_W = 32;               // signed coordinate width
    localparam int D_W     = COORD_W + 1;      // axis difference / magnitude
    localparam int SQ_W    = 2 * D_W;          // squared magnitude and sum of squares
    localparam int ROOT_W  = D_W + 1;          // segment length (floor sqrt)
    localparam int RAD_W   = 2 * ROOT_W;       // radicand padded to whole digit pairs
    localparam int TRIM_W  = 31;               // trim distance / remaining trim
    localparam int TOL_W   = 8;                // equality tolerance
    localparam int NUM_W   = D_W + TRIM_W;     // interpolation numerator
    localparam int CNT_W   = $clog2(ROOT_W);   // iteration counter
    localparam int CFG_W   = TRIM_W;           // widest register
    localparam int AX_W    = 2;                // axis select

    // Register indexes on the configuration port
    localparam logic REG_TRIM = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    // Axis selects
    localparam logic [AX_W-1:0] AX_X = 2'd0;
    localparam logic [AX_W-1:0] AX_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_CHECK,
        ST_PR_MUL,
        ST_PR_STORE,
        ST_DIV,
        ST_SET_START,
        ST_CMP,
        ST_OUT1,
        ST_OUT2
    } t_state;

    typedef enum logic [1:0] {
        PH_AWAIT,
        PH_TRIM,
        PH_PASS,
        PH_THRU
    } t_phase;

    // What the output register loads
    typedef enum logic [1:0] {
        OS_POINT,
        OS_START,
        OS_MARK
    } t_osel;

    typedef struct packed {
        logic            load_in;
        logic            init_trim;
        logic            mul_sq;
        logic            mul_div;
        logic            acc_clr;
        logic            acc_add;
        logic            sqrt_start;
        logic            sqrt_step;
        logic            div_load;
        logic            div_step;
        logic            start_set;
        logic            trim_adv;
        logic            end_set;
        logic            out_load;
        t_osel           out_sel;
        logic            out_valid;
        logic            out_final;
        logic [AX_W-1:0] ax;
    } t_dp_cmd;

    typedef struct packed {
        logic pt_end;
        logic trim_zero;
        logic same_start;
        logic reach;
        logic iter_done;
    } t_dp_sts;

endpackage

### sv/polyline_leading_trim_core.sv
// Top level of the polyline leading-trim block: controller plus datapath.
// Depends on plt_pkg, plt_ctrl and plt_dp.
//
// Input stream: tdata = {pos_z, pos_y, pos_x} (pos_x lowest), tlast = path_end.
// Output stream: tdata = {out_z, out_y, out_x}, tuser = point_valid,
// tlast = final_result. Config: i_cfg_we writes register i_cfg_idx
// (0 trim_distance, 1 equal_tolerance) from i_cfg_wdata.
// One point is processed at a time; the input is ready only while idle.
// A passed point, or a first point that ends the path or meets zero trim,
// goes from the point register to the output register. A point in the trim
// phase runs the segment length: 3 multiplies of the shared 33x33
// multiplier and a bit-serial square root, then when the cut is reached
// 3 more multiplies and a bit-serial divide on three lanes.
// Up to two results come out of one point, each held in the output register
// until the receiver takes it; a stalled receiver stalls the input.
// Reset (synchronous, active low) clears both registers to zero and
// returns the path to awaiting its first point.
module polyline_leading_trim_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_idx,
    input  logic [plt_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [3*plt_pkg::COORD_W-1:0]          i_s_tdata,   // pos_x, pos_y, pos_z
    input  logic                                   i_s_tlast,   // path_end
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [3*plt_pkg::COORD_W-1:0]          o_m_tdata,   // out_x, out_y, out_z
    output logic                                   o_m_tuser,   // point_valid
    output logic                                   o_m_tlast    // final_result
);
    import plt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    plt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt_data   (i_s_tdata),
        .i_pt_end    (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_m_tdata),
        .o_out_valid (o_m_tuser),
        .o_out_final (o_m_tlast)
    );

endmodule

### sv/plt_dp.sv
// Datapath of the leading-trim block: point, config and trim registers, a shared
// multiplier, bit-serial square root and three parallel divider lanes.
// Depends on plt_pkg.
module plt_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_idx,
    input  logic [plt_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic [3*plt_pkg::COORD_W-1:0]          i_pt_data,
    input  logic                                   i_pt_end,
    input  plt_pkg::t_dp_cmd                       i_cmd,
    output plt_pkg::t_dp_sts                       o_sts,
    output logic [3*plt_pkg::COORD_W-1:0]          o_out_data,
    output logic                                   o_out_valid,
    output logic                                   o_out_final
);
    import plt_pkg::*;

    logic [TRIM_W-1:0]         r_trim;
    logic [TOL_W-1:0]          r_tol;
    logic [COORD_W-1:0]        r_pt    [3];
    logic                      r_end;
    logic [COORD_W-1:0]        r_prev  [3];
    logic [COORD_W-1:0]        r_start [3];
    logic [TRIM_W-1:0]         r_rem;
    logic [SQ_W-1:0]           r_prod;
    logic [SQ_W-1:0]           r_acc;
    logic [RAD_W-1:0]          r_rad;
    logic [ROOT_W+1:0]         r_srem;
    logic [ROOT_W-1:0]         r_root;
    logic [ROOT_W-1:0]         r_drem  [3];
    logic [TRIM_W-1:0]         r_dlow  [3];
    logic [TRIM_W-1:0]         r_dq    [3];
    logic [CNT_W-1:0]          r_cnt;
    logic [COORD_W-1:0]        r_out   [3];
    logic                      r_oval;
    logic                      r_ofin;

    logic [D_W-1:0]            w_d     [3];
    logic [D_W-1:0]            w_mag   [3];
    logic                      w_same  [3];
    logic [D_W-1:0]            w_ma;
    logic [D_W-1:0]            w_mb;
    logic [ROOT_W+3:0]         w_st;
    logic [ROOT_W+3:0]         w_strial;
    logic [ROOT_W:0]           w_dt    [3];
    logic [COORD_W-1:0]        w_off   [3];

    // Per-axis difference, magnitude, and start-point match
    always_comb begin
        logic [D_W-1:0] e;
        logic [D_W-1:0] em;
        for (int a = 0; a < 3; a++) begin
            w_d[a]   = {r_pt[a][COORD_W-1], r_pt[a]} - {r_prev[a][COORD_W-1], r_prev[a]};
            w_mag[a] = w_d[a][D_W-1] ? (D_W)'(0) - w_d[a] : w_d[a];
            e        = {r_pt[a][COORD_W-1], r_pt[a]} - {r_start[a][COORD_W-1], r_start[a]};
            em       = e[D_W-1] ? (D_W)'(0) - e : e;
            w_same[a] = (em <= (D_W)'(r_tol));
            w_off[a] = w_d[a][D_W-1] ? (COORD_W)'(0) - (COORD_W)'(r_dq[a])
                                     : (COORD_W)'(r_dq[a]);
            w_dt[a]  = {r_drem[a], r_dlow[a][TRIM_W-1]};
        end
    end

    // Multiplier operand select
    always_comb begin
        unique case (i_cmd.ax)
            2'd0:    w_ma = w_mag[0];
            2'd1:    w_ma = w_mag[1];
            2'd2:    w_ma = w_mag[2];
            default: w_ma = '0;
        endcase
        w_mb = i_cmd.mul_sq ? w_ma : (D_W)'(r_rem);
    end

    // Square-root digit step
    assign w_st     = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_strial = {2'b00, r_root, 2'b01};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
            r_tol  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRIM: r_trim <= i_cfg_wdata[TRIM_W-1:0];
                REG_TOL:  r_tol  <= i_cfg_wdata[TOL_W-1:0];
                default:  r_trim <= r_trim;
            endcase
        end
    end

    // Path state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a]  <= '0;
                r_start[a] <= '0;
            end
            r_rem <= '0;
        end else begin
            if (i_cmd.init_trim) begin
                for (int a = 0; a < 3; a++) r_prev[a] <= r_pt[a];
                r_rem <= r_trim;
            end
            if (i_cmd.trim_adv) begin
                for (int a = 0; a < 3; a++) r_prev[a] <= r_pt[a];
                r_rem <= r_rem - r_root[TRIM_W-1:0];
            end
            if (i_cmd.end_set) begin
                for (int a = 0; a < 3; a++) r_start[a] <= r_pt[a];
            end
            if (i_cmd.start_set) begin
                for (int a = 0; a < 3; a++) r_start[a] <= r_prev[a] + w_off[a];
            end
        end
    end

    // Input point, multiplier, sqrt and divider lanes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int a = 0; a < 3; a++) r_pt[a] <= i_pt_data[a*COORD_W +: COORD_W];
            r_end <= i_pt_end;
        end
        if (i_cmd.mul_sq || i_cmd.mul_div) r_prod <= w_ma * w_mb;
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (i_cmd.acc_add) r_acc <= r_acc + r_prod;
        if (i_cmd.sqrt_start) begin
            r_rad  <= (RAD_W)'(r_acc);
            r_srem <= '0;
            r_root <= '0;
            r_cnt  <= (CNT_W)'(ROOT_W - 1);
        end else if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt - 1'b1;
            if (w_st >= w_strial) begin
                r_srem <= (ROOT_W+2)'(w_st - w_strial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= w_st[ROOT_W+1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_load) begin
            for (int a = 0; a < 3; a++) begin
                if (i_cmd.ax == (AX_W)'(a)) begin
                    r_drem[a] <= (ROOT_W)'(r_prod[NUM_W-1:TRIM_W]);
                    r_dlow[a] <= r_prod[TRIM_W-1:0];
                    r_dq[a]   <= '0;
                end
            end
            r_cnt <= (CNT_W)'(TRIM_W - 1);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            for (int a = 0; a < 3; a++) begin
                r_dlow[a] <= r_dlow[a] << 1;
                if (w_dt[a] >= {1'b0, r_root}) begin
                    r_drem[a] <= (ROOT_W)'(w_dt[a] - {1'b0, r_root});
                    r_dq[a]   <= {r_dq[a][TRIM_W-2:0], 1'b1};
                end else begin
                    r_drem[a] <= w_dt[a][ROOT_W-1:0];
                    r_dq[a]   <= {r_dq[a][TRIM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oval <= i_cmd.out_valid;
            r_ofin <= i_cmd.out_final;
            for (int a = 0; a < 3; a++) begin
                unique case (i_cmd.out_sel)
                    OS_POINT: r_out[a] <= r_pt[a];
                    OS_START: r_out[a] <= r_start[a];
                    default:  r_out[a] <= '0;
                endcase
            end
        end
    end

    assign o_out_data  = {r_out[2], r_out[1], r_out[0]};
    assign o_out_valid = r_oval;
    assign o_out_final = r_ofin;

    assign o_sts.pt_end     = r_end;
    assign o_sts.trim_zero  = (r_trim == '0);
    assign o_sts.same_start = w_same[0] && w_same[1] && w_same[2];
    assign o_sts.reach      = (r_root >= (ROOT_W)'(r_rem)) && (r_root != '0);
    assign o_sts.iter_done  = (r_cnt == '0);

endmodule

### sv/plt_ctrl.sv
// Controller of the leading-trim block: path phase and per-item sequencer.
// Drives plt_dp through t_dp_cmd; depends on plt_pkg.
module plt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  plt_pkg::t_dp_sts i_sts,
    output plt_pkg::t_dp_cmd o_cmd
);
    import plt_pkg::*;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [AX_W-1:0] r_ax, n_ax;
    logic            r_second, n_second;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_AWAIT;
            r_ax     <= AX_X;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ax     <= n_ax;
            r_second <= n_second;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT1) || (r_state == ST_OUT2);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_ax     = r_ax;
        n_second = r_second;
        o_cmd    = '0;
        o_cmd.ax = r_ax;
        o_cmd.out_sel = OS_POINT;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_second = 1'b0;
                unique case (r_phase)
                    PH_AWAIT: begin
                        if (i_sts.pt_end) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_valid = 1'b1;
                            o_cmd.out_final = 1'b1;
                            n_state = ST_OUT1;
                        end else if (i_sts.trim_zero) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_valid = 1'b1;
                            n_phase = PH_THRU;
                            n_state = ST_OUT1;
                        end else begin
                            o_cmd.init_trim = 1'b1;
                            n_phase = PH_TRIM;
                            n_state = ST_IDLE;
                        end
                    end
                    PH_TRIM: begin
                        o_cmd.acc_clr = 1'b1;
                        n_ax = AX_X;
                        n_state = ST_SQ_MUL;
                    end
                    PH_PASS: begin
                        if (i_sts.same_start) begin
                            if (i_sts.pt_end) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_sel = OS_MARK;
                                o_cmd.out_final = 1'b1;
                                n_phase = PH_AWAIT;
                                n_state = ST_OUT1;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_valid = 1'b1;
                            o_cmd.out_final = i_sts.pt_end;
                            if (i_sts.pt_end) n_phase = PH_AWAIT;
                            n_state = ST_OUT1;
                        end
                    end
                    default: begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_valid = 1'b1;
                        o_cmd.out_final = i_sts.pt_end;
                        if (i_sts.pt_end) n_phase = PH_AWAIT;
                        n_state = ST_OUT1;
                    end
                endcase
            end
            // Sum of squares, one axis per multiply
            ST_SQ_MUL: begin
                o_cmd.mul_sq = 1'b1;
                n_state = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (r_ax == AX_Z) begin
                    n_state = ST_SQRT_INIT;
                end else begin
                    n_ax = r_ax + 1'b1;
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQRT_INIT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.iter_done) n_state = ST_CHECK;
            end
            // Segment reaches the remaining trim, or is consumed whole
            ST_CHECK: begin
                if (i_sts.reach) begin
                    n_ax = AX_X;
                    n_state = ST_PR_MUL;
                end else begin
                    o_cmd.trim_adv = 1'b1;
                    if (i_sts.pt_end) begin
                        o_cmd.end_set = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_valid = 1'b1;
                        o_cmd.out_final = 1'b1;
                        n_second = 1'b0;
                        n_phase = PH_AWAIT;
                        n_state = ST_OUT1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            // Interpolation numerators, then all three divisions together
            ST_PR_MUL: begin
                o_cmd.mul_div = 1'b1;
                n_state = ST_PR_STORE;
            end
            ST_PR_STORE: begin
                o_cmd.div_load = 1'b1;
                if (r_ax == AX_Z) begin
                    n_state = ST_DIV;
                end else begin
                    n_ax = r_ax + 1'b1;
                    n_state = ST_PR_MUL;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.iter_done) n_state = ST_SET_START;
            end
            ST_SET_START: begin
                o_cmd.start_set = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel = OS_START;
                o_cmd.out_valid = 1'b1;
                o_cmd.out_final = i_sts.same_start && i_sts.pt_end;
                n_second = !i_sts.same_start;
                n_phase = i_sts.pt_end ? PH_AWAIT : PH_PASS;
                n_state = ST_OUT1;
            end
            // Result transfers
            ST_OUT1: begin
                if (i_m_tready) begin
                    if (r_second) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_valid = 1'b1;
                        o_cmd.out_final = i_sts.pt_end;
                        n_second = 1'b0;
                        n_state = ST_OUT2;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT2: begin
                if (i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### tb/sv/tb_polyline_leading_trim_core.sv
// Self-checking bench for polyline_leading_trim_core: random 3D paths with random
// stream idling, checked point by point against a behavioral path-trim predictor.
// Depends on plt_pkg and the core RTL.
`timescale 1ns / 1ps

class plt_scoreboard;
    typedef struct {
        logic signed [31:0] x, y, z;
        logic               pvalid;
        logic               fin;
    } t_res;

    logic [30:0]        trim_reg;
    logic [7:0]         tol_reg;
    logic signed [63:0] prev_pt[3];
    logic signed [63:0] start_pt[3];
    logic [63:0]        rem_trim;
    plt_pkg::t_phase    phase;
    t_res               pending[$];
    int                 n_err;

    function new();
        trim_reg = '0;
        tol_reg  = '0;
        rem_trim = '0;
        phase    = plt_pkg::PH_AWAIT;
        n_err    = 0;
        for (int a = 0; a < 3; a++) begin
            prev_pt[a]  = 0;
            start_pt[a] = 0;
        end
    endfunction

    function void write_reg(logic idx, logic [30:0] val);
        if (idx == plt_pkg::REG_TRIM) trim_reg = val;
        else tol_reg = val[7:0];
    endfunction

    function void push(logic signed [63:0] p[3], bit v, bit f);
        t_res r;
        r.x = p[0][31:0];
        r.y = p[1][31:0];
        r.z = p[2][31:0];
        r.pvalid = v;
        r.fin    = f;
        pending.push_back(r);
    endfunction

    function bit near_start(logic signed [63:0] p[3]);
        logic signed [63:0] d;
        for (int a = 0; a < 3; a++) begin
            d = p[a] - start_pt[a];
            if (d < 0) d = -d;
            if (d > tol_reg) return 0;
        end
        return 1;
    endfunction

    // floor square root of a sum of squares up to 66 bits
    function logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    // note one accepted input point and queue what it produces
    function void note_point(logic [95:0] data, bit last);
        logic signed [63:0] p[3];
        logic signed [63:0] d[3];
        logic signed [63:0] zero3[3];
        logic [127:0]       sq;
        logic [127:0]       m;
        logic [63:0]        seg, off;
        for (int a = 0; a < 3; a++) begin
            p[a] = $signed(data[a*32 +: 32]);
            zero3[a] = 0;
        end
        case (phase)
            plt_pkg::PH_AWAIT: begin
                if (last) push(p, 1, 1);
                else if (trim_reg == 0) begin
                    push(p, 1, 0);
                    phase = plt_pkg::PH_THRU;
                end else begin
                    prev_pt  = p;
                    rem_trim = trim_reg;
                    phase    = plt_pkg::PH_TRIM;
                end
            end
            plt_pkg::PH_TRIM: begin
                sq = 0;
                for (int a = 0; a < 3; a++) begin
                    d[a] = p[a] - prev_pt[a];
                    m = (d[a] < 0) ? -d[a] : d[a];
                    sq += m * m;
                end
                seg = isqrt(sq);
                if (seg >= rem_trim && seg != 0) begin
                    for (int a = 0; a < 3; a++) begin
                        m = (d[a] < 0) ? -d[a] : d[a];
                        off = (m * rem_trim) / seg;
                        start_pt[a] = prev_pt[a] + ((d[a] < 0) ? -$signed(off) : $signed(off));
                    end
                    if (near_start(p)) push(start_pt, 1, last);
                    else begin
                        push(start_pt, 1, 0);
                        push(p, 1, last);
                    end
                    phase = last ? plt_pkg::PH_AWAIT : plt_pkg::PH_PASS;
                end else begin
                    rem_trim -= seg;
                    prev_pt = p;
                    if (last) begin
                        start_pt = p;
                        push(p, 1, 1);
                        phase = plt_pkg::PH_AWAIT;
                    end
                end
            end
            plt_pkg::PH_PASS: begin
                if (near_start(p)) begin
                    if (last) begin
                        push(zero3, 0, 1);
                        phase = plt_pkg::PH_AWAIT;
                    end
                end else begin
                    push(p, 1, last);
                    if (last) phase = plt_pkg::PH_AWAIT;
                end
            end
            default: begin
                push(p, 1, last);
                if (last) phase = plt_pkg::PH_AWAIT;
            end
        endcase
    endfunction

    // compare one accepted output point with the oldest expectation
    function void check_point(logic [95:0] data, bit v, bit f);
        t_res e;
        if (pending.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected result %h v=%0b f=%0b", data, v, f);
            return;
        end
        e = pending.pop_front();
        if (data !== {e.z, e.y, e.x} || v !== e.pvalid || f !== e.fin) begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch: exp %h %h %h v=%0b f=%0b, got %h %h %h v=%0b f=%0b",
                         e.x, e.y, e.z, e.pvalid, e.fin,
                         data[31:0], data[63:32], data[95:64], v, f);
        end
    endfunction
endclass

module tb_polyline_leading_trim_core;
    import plt_pkg::*;

    localparam int WATCHDOG = 20000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [95:0]      i_s_tdata = '0;
    logic             i_s_tlast = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [95:0]      o_m_tdata;
    logic             o_m_tuser;
    logic             o_m_tlast;

    plt_scoreboard sb;
    int  src_idle_pct;   // sender idle chance, percent
    int  snk_stall_pct;  // receiver stall chance, percent
    int  hold_off;       // remaining cycles of a forced receiver hold-off
    int  quiet_cycles;
    logic signed [31:0] cur[3];

    polyline_leading_trim_core u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // scoreboard sampling and watchdog at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_point(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_point(o_m_tdata, o_m_tuser, o_m_tlast);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("timeout");
                $display("tb_polyline_leading_trim_core: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall, plus hold-off counted here
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // register write once the block has nothing in flight
    task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (!o_s_tready || o_m_tvalid || sb.pending.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one point and hold it until transferred
    task automatic send_point(logic signed [31:0] x, y, z, bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // random path: a mix of small steps, exact repeats, tiny moves and huge jumps
    task automatic send_path(int len);
        for (int a = 0; a < 3; a++) cur[a] = $signed($urandom_range(20000)) - 10000;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0: for (int a = 0; a < 3; a++) cur[a] = $signed($urandom());
                1: ;
                2: for (int a = 0; a < 3; a++) cur[a] += $signed($urandom_range(4)) - 2;
                default:
                    for (int a = 0; a < 3; a++) cur[a] += $signed($urandom_range(3000)) - 1500;
            endcase
            send_point(cur[0], cur[1], cur[2], k == len - 1);
        end
    endtask

    initial begin
        sb = new();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off      = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pass-through with zero trim, extremes, one-point paths
        send_point(32'sh7fffffff, 32'sh80000000, 0, 0);
        send_point(32'sh80000000, 32'sh7fffffff, -1, 1);
        send_point(5, 6, 7, 1);
        drain();
        write_cfg(REG_TRIM, 31'h7fffffff);
        write_cfg(REG_TOL, 8'hff);
        // trim longer than path, then huge segments
        send_point(0, 0, 0, 0);
        send_point(100, 0, 0, 0);
        send_point(200, 0, 0, 1);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        drain();
        write_cfg(REG_TRIM, 31'd100);
        write_cfg(REG_TOL, 8'd0);
        // cut equals reaching point; skipped final duplicate
        send_point(0, 0, 0, 0);
        send_point(100, 0, 0, 0);
        send_point(100, 0, 0, 1);
        send_point(0, 0, 0, 0);
        send_point(0, 300, 0, 0);
        send_point(0, 400, -5, 0);
        send_point(0, 400, 0, 1);
        // zero-length segment then reach
        send_point(7, 7, 7, 0);
        send_point(7, 7, 7, 0);
        send_point(-200, 7, 7, 1);
        drain();
        write_cfg(REG_TOL, 8'd10);
        send_point(0, 0, 0, 0);
        send_point(0, 0, 50, 0);
        write_cfg(REG_TOL, 8'd200);  // tolerance read at every compare
        send_point(0, 0, 150, 0);
        send_point(0, 5, 100, 1);
        drain();

        // random phases with different idling and settings
        for (int ph = 0; ph < 5; ph++) begin
            int n;
            int len;
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                3: begin src_idle_pct = 24; snk_stall_pct = 24; end
                default: begin src_idle_pct = 0; snk_stall_pct = 10; end
            endcase
            write_cfg(REG_TRIM, (ph == 4) ? 31'd0 : 31'($urandom_range(6000)));
            write_cfg(REG_TOL, 31'($urandom_range(255)));
            if (ph == 0) hold_off = 3000;
            n = 0;
            while (n < 260) begin
                len = $urandom_range(8, 1);
                send_path(len);
                n += len;
            end
            drain();
        end

        if (sb.n_err == 0) begin
            $display("tb_polyline_leading_trim_core: PASS");
        end else begin
            $display("tb_polyline_leading_trim_core: FAIL");
        end
        $finish;
    end
endmodule
